// ===== rtl/csrmm_pkg.sv =====
`timescale 1ns / 1ps

package csrmm_pkg;

    // Field widths of the input and result transactions
    localparam int CMD_W       = 2;
    localparam int POS_W       = 11;
    localparam int PTR_W       = 11;
    localparam int INNER_W     = 8;
    localparam int DCOL_W      = 4;
    localparam int VAL_W       = 32;
    localparam int ROW_OUT_W   = 8;
    localparam int STATUS_W    = 2;

    // Configuration register widths and port
    localparam int ROWS_REG_W  = 9;
    localparam int DCOLS_REG_W = 5;
    localparam int INNER_REG_W = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    // Product, rounded term and accumulator widths
    localparam int PROD_W      = 2 * VAL_W;
    localparam int FRAC_W      = 16;
    localparam int TERM_W      = PROD_W - FRAC_W;
    localparam int ACC_W       = TERM_W + PTR_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROW_PTR = 2'd0,
        CMD_NONZERO = 2'd1,
        CMD_DENSE   = 2'd2,
        CMD_COMPUTE = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_RANGE     = 2'd1,
        STS_BAD_COL   = 2'd2,
        STS_SATURATED = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DENSE_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM      = 2'd2;

    localparam logic [ROWS_REG_W-1:0]  ROWS_RESET  = 9'd256;
    localparam logic [DCOLS_REG_W-1:0] DCOLS_RESET = 5'd16;
    localparam logic [INNER_REG_W-1:0] INNER_RESET = 9'd256;

endpackage

// ===== rtl/csr_sparse_dense_matmul.sv =====
`timescale 1ns / 1ps

// CSR sparse matrix times dense matrix, one C element per compute transaction.
// Input channel (i_valid / o_stall) carries load and compute commands. Loads
// write the row pointer table, the nonzero store or the dense matrix and
// produce no result. A compute names row i_position and
// column i_dense_col and yields one result transaction on the output channel
// (o_valid / i_stall) with value, echoed row and column, and status.
// A compute walks the row's N nonzeros one per cycle through a shared
// memory-read / multiply / round-accumulate pipeline after a row pointer read;
// a bad nonzero column ends the walk early, and an out-of-range request goes
// straight to the finish step. The block holds o_stall high from the cycle after
// a compute is accepted until its result is loaded into the output register.
// The output register lets the next load be accepted while a result waits.
// If the receiver stalls, a finished compute waits in its last step until
// the output register frees up. Configuration writes (i_cfg_valid /
// o_cfg_ready) are taken whenever no compute is in progress.
// Synchronous reset restores the register defaults and clears all control
// state; the memories keep their contents and must be loaded before use.
module csr_sparse_dense_matmul #(
    parameter int MAX_ROWS       = 256,
    parameter int MAX_NONZEROS   = 1024,
    parameter int MAX_INNER      = 256,
    parameter int MAX_DENSE_COLS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [csrmm_pkg::CMD_W-1:0]           i_command,
    input  logic [csrmm_pkg::POS_W-1:0]           i_position,
    input  logic [csrmm_pkg::PTR_W-1:0]           i_pointer_value,
    input  logic [csrmm_pkg::INNER_W-1:0]         i_inner_index,
    input  logic [csrmm_pkg::DCOL_W-1:0]          i_dense_col,
    input  logic signed [csrmm_pkg::VAL_W-1:0]    i_value,
    // Output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [csrmm_pkg::VAL_W-1:0]    o_result,
    output logic [csrmm_pkg::ROW_OUT_W-1:0]       o_out_row,
    output logic [csrmm_pkg::DCOL_W-1:0]          o_out_col,
    output logic [csrmm_pkg::STATUS_W-1:0]        o_status,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [csrmm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [csrmm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int RP_DEPTH = MAX_ROWS + 1;
    localparam int RP_A_W   = $clog2(RP_DEPTH);
    localparam int NZ_A_W   = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int D_DEPTH  = MAX_INNER * MAX_DENSE_COLS;
    localparam int D_A_W    = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;

    localparam int PTR_W  = csrmm_pkg::PTR_W;
    localparam int VAL_W  = csrmm_pkg::VAL_W;
    localparam int ACC_W  = csrmm_pkg::ACC_W;
    localparam int TERM_W = csrmm_pkg::TERM_W;
    localparam int PROD_W = csrmm_pkg::PROD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PTR,
        ST_WALK,
        ST_FINISH
    } t_state;

    // Control state
    t_state r_state, n_state;
    logic [csrmm_pkg::ROWS_REG_W-1:0]  r_num_rows;
    logic [csrmm_pkg::DCOLS_REG_W-1:0] r_num_dcols;
    logic [csrmm_pkg::INNER_REG_W-1:0] r_inner_dim;
    logic [PTR_W-1:0]                  r_k, n_k;
    logic [PTR_W-1:0]                  r_end, n_end;
    logic                              r_v1, r_v2, r_v3;
    logic                              n_v1, n_v2;
    logic                              r_bad, n_bad;
    logic                              r_oor, n_oor;
    logic signed [ACC_W-1:0]           r_acc, n_acc;
    logic [csrmm_pkg::ROW_OUT_W-1:0]   r_row, n_row;
    logic [csrmm_pkg::DCOL_W-1:0]      r_col, n_col;
    logic                              r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0]           r_result, n_result;
    logic [csrmm_pkg::ROW_OUT_W-1:0]   r_out_row, n_out_row;
    logic [csrmm_pkg::DCOL_W-1:0]      r_out_col, n_out_col;
    logic [csrmm_pkg::STATUS_W-1:0]    r_status, n_status;

    // Datapath registers
    logic [PTR_W-1:0]                  r_rp_start, r_rp_end;
    logic [csrmm_pkg::INNER_W-1:0]     r_nz_col;
    logic signed [VAL_W-1:0]           r_nz_val;
    logic signed [VAL_W-1:0]           r_dense_rd;
    logic signed [VAL_W-1:0]           r_s2_val;
    logic signed [PROD_W-1:0]          r_prod;

    // Memories
    logic [PTR_W-1:0]                  r_rp_mem [RP_DEPTH];
    logic [csrmm_pkg::INNER_W-1:0]     r_nzc_mem [MAX_NONZEROS];
    logic signed [VAL_W-1:0]           r_nzv_mem [MAX_NONZEROS];
    logic signed [VAL_W-1:0]           r_d_mem [D_DEPTH];

    logic              in_acc;
    logic              req_ok;
    logic              col_ok;
    logic              issue;
    logic              walk_done;
    logic              sat;
    logic              out_free;
    logic [RP_A_W-1:0] rp_addr;
    logic [D_A_W-1:0]  d_wr_addr;
    logic [D_A_W-1:0]  d_rd_addr;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [TERM_W-1:0] term;

    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_valid && !o_stall;

    assign o_valid   = r_out_valid;
    assign o_result  = r_result;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_status  = r_status;

    // Request range check against the smaller of register and storage
    assign req_ok = (32'(i_position) < 32'(r_num_rows)) && (32'(i_position) < MAX_ROWS)
                 && (32'(i_dense_col) < 32'(r_num_dcols))
                 && (32'(i_dense_col) < MAX_DENSE_COLS);

    // Column check of the nonzero in stage 1
    assign col_ok = (32'(r_nz_col) < 32'(r_inner_dim)) && (32'(r_nz_col) < MAX_INNER);

    assign issue     = (r_state == ST_WALK) && (r_k < r_end) && !r_bad && !(r_v1 && !col_ok);
    assign walk_done = (r_state == ST_WALK) && !issue && !r_v1 && !r_v2 && !r_v3;

    assign rp_addr   = RP_A_W'(i_position);
    assign d_wr_addr = D_A_W'(32'(i_inner_index) * MAX_DENSE_COLS + 32'(i_dense_col));
    assign d_rd_addr = D_A_W'(32'(r_nz_col) * MAX_DENSE_COLS + 32'(r_col));

    // Round half up to Q16.16: add half an LSB, drop the fraction
    assign prod_rnd = r_prod + PROD_W'(64'sd32768);
    assign term     = prod_rnd[PROD_W-1:csrmm_pkg::FRAC_W];

    // Saturation: the bits above bit 31 must all match the sign
    assign sat      = !((&r_acc[ACC_W-1:VAL_W-1]) || !(|r_acc[ACC_W-1:VAL_W-1]));
    assign out_free = !r_out_valid || !i_stall;

    // Sequencer and output register next state
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_end       = r_end;
        n_v1        = issue;
        n_v2        = r_v1 && col_ok && !r_bad;
        n_bad       = r_bad;
        n_oor       = r_oor;
        n_acc       = r_acc;
        n_row       = r_row;
        n_col       = r_col;
        n_out_valid = r_out_valid && i_stall;
        n_result    = r_result;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_status    = r_status;

        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_command == csrmm_pkg::CMD_COMPUTE)) begin
                    n_row = i_position[csrmm_pkg::ROW_OUT_W-1:0];
                    n_col = i_dense_col;
                    n_acc = '0;
                    n_bad = 1'b0;
                    n_oor = !req_ok;
                    n_state = req_ok ? ST_PTR : ST_FINISH;
                end
            end
            ST_PTR: begin
                n_k = r_rp_start;
                n_end = (32'(r_rp_end) > MAX_NONZEROS) ? PTR_W'(MAX_NONZEROS) : r_rp_end;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (issue) begin
                    n_k = r_k + PTR_W'(1);
                end
                if (r_v1 && !col_ok) begin
                    n_bad = 1'b1;
                end
                if (r_v3) begin
                    n_acc = r_acc + ACC_W'(term);
                end
                if (walk_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_row;
                    n_out_col   = r_col;
                    if (r_oor) begin
                        n_result = '0;
                        n_status = csrmm_pkg::STS_RANGE;
                    end else if (r_bad) begin
                        n_result = '0;
                        n_status = csrmm_pkg::STS_BAD_COL;
                    end else if (sat) begin
                        n_result = r_acc[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                  : {1'b0, {(VAL_W-1){1'b1}}};
                        n_status = csrmm_pkg::STS_SATURATED;
                    end else begin
                        n_result = r_acc[VAL_W-1:0];
                        n_status = csrmm_pkg::STS_OK;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num_rows  <= csrmm_pkg::ROWS_RESET;
            r_num_dcols <= csrmm_pkg::DCOLS_RESET;
            r_inner_dim <= csrmm_pkg::INNER_RESET;
            r_k         <= '0;
            r_end       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_bad       <= 1'b0;
            r_oor       <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_end       <= n_end;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_v3        <= r_v2;
            r_bad       <= n_bad;
            r_oor       <= n_oor;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    csrmm_pkg::CFG_NUM_ROWS: begin
                        r_num_rows <= i_cfg_data[csrmm_pkg::ROWS_REG_W-1:0];
                    end
                    csrmm_pkg::CFG_NUM_DENSE_COLS: begin
                        r_num_dcols <= i_cfg_data[csrmm_pkg::DCOLS_REG_W-1:0];
                    end
                    csrmm_pkg::CFG_INNER_DIM: begin
                        r_inner_dim <= i_cfg_data[csrmm_pkg::INNER_REG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        r_row     <= n_row;
        r_col     <= n_col;
        r_result  <= n_result;
        r_out_row <= n_out_row;
        r_out_col <= n_out_col;
        r_status  <= n_status;
    end

    // Row pointer table: one write port, two read ports (start and end)
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_command == csrmm_pkg::CMD_ROW_PTR)
            && (32'(i_position) <= MAX_ROWS)) begin
            r_rp_mem[rp_addr] <= i_pointer_value;
        end
        r_rp_start <= r_rp_mem[rp_addr];
        r_rp_end   <= r_rp_mem[RP_A_W'(32'(i_position) + 1)];
    end

    // Nonzero store, read at the walk pointer
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_command == csrmm_pkg::CMD_NONZERO)
            && (32'(i_position) < MAX_NONZEROS)) begin
            r_nzc_mem[NZ_A_W'(i_position)] <= i_inner_index;
            r_nzv_mem[NZ_A_W'(i_position)] <= i_value;
        end
        r_nz_col <= r_nzc_mem[NZ_A_W'(r_k)];
        r_nz_val <= r_nzv_mem[NZ_A_W'(r_k)];
    end

    // Dense matrix, read at the nonzero's column and the requested column
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_command == csrmm_pkg::CMD_DENSE)
            && (32'(i_inner_index) < MAX_INNER)
            && (32'(i_dense_col) < MAX_DENSE_COLS)) begin
            r_d_mem[d_wr_addr] <= i_value;
        end
        r_dense_rd <= r_d_mem[d_rd_addr];
    end

    // Shared multiplier: value aligned with the dense read, then product
    always_ff @(posedge i_clk) begin
        r_s2_val <= r_nz_val;
        r_prod   <= r_dense_rd * r_s2_val;
    end

endmodule
